### rtl/hac_pkg.sv
// hac_pkg: shared constants, request/status codes and controller/datapath
// interface structs for the horizon altitude check unit. No dependencies.
`timescale 1ns / 1ps

package hac_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int AZ_W       = 16;
  localparam int ALT_W      = 15;
  localparam int ENT_W      = AZ_W + ALT_W;
  localparam int FULL_TURN  = 36000;
  localparam int ALT_LIMIT  = 9000;
  localparam int DEN_W      = 16;
  localparam int DIFF_W     = 16;
  localparam int PROD_W     = DEN_W + 1 + DIFF_W;
  localparam int DIV_W      = 32;
  localparam int DIVCNT_W   = $clog2(DIV_W);
  localparam int SUM_W      = DIV_W + 2;

  localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(ALT_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic res_zero;
    logic res_full;
    logic res_empty;
    logic idx_last;
    logic idx_zero;
    logic idx_inc;
    logic idx_dec;
    logic rd;
    logic wr_shift;
    logic wr_new_up;
    logic wr_new_zero;
    logic cnt_inc;
    logic q_save;
    logic pair_prev;
    logic pair_wrap;
    logic sub;
    logic mul;
    logic prep;
    logic div_step;
    logic fin;
    logic post;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic empty;
    logic full;
    logic az_gt;
    logic at_first;
    logic at_last;
    logic div_last;
    logic out_busy;
  } sts_t;

  function automatic logic signed [ALT_W-1:0] clamp_alt(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > LIM_HI) r = LIM_HI;
    if (v < LIM_LO) r = LIM_LO;
    return ALT_W'(r);
  endfunction

endpackage

### rtl/hac_ram.sv
// hac_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### rtl/hac_ctrl.sv
// hac_ctrl: request sequencer for the horizon table. Drives datapath commands
// from datapath status. Depends on hac_pkg.
`timescale 1ns / 1ps

module hac_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hac_pkg::sts_t sts,
  output hac_pkg::cmd_t cmd
);
  import hac_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_DECODE = 15'b000000000000010,
    S_I_RD   = 15'b000000000000100,
    S_I_CHK  = 15'b000000000001000,
    S_I_LAST = 15'b000000000010000,
    S_Q_RD   = 15'b000000000100000,
    S_Q_CHK  = 15'b000000001000000,
    S_Q_LRD  = 15'b000000010000000,
    S_Q_LCHK = 15'b000000100000000,
    S_SUB    = 15'b000001000000000,
    S_MUL    = 15'b000010000000000,
    S_PREP   = 15'b000100000000000,
    S_DIV    = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_POST   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_zero = 1'b1;
            state_next   = S_POST;
          end
          REQ_INSERT: begin
            if (sts.full) begin
              cmd.res_full = 1'b1;
              state_next   = S_POST;
            end else if (sts.empty) begin
              cmd.wr_new_zero = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.res_zero    = 1'b1;
              state_next      = S_POST;
            end else begin
              cmd.idx_last = 1'b1;
              state_next   = S_I_RD;
            end
          end
          REQ_QUERY: begin
            if (sts.empty) begin
              cmd.res_empty = 1'b1;
              state_next    = S_POST;
            end else begin
              cmd.idx_zero = 1'b1;
              state_next   = S_Q_RD;
            end
          end
          default: begin
            cmd.res_zero = 1'b1;
            state_next   = S_POST;
          end
        endcase
      end
      S_I_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_I_CHK;
      end
      S_I_CHK: begin
        if (sts.az_gt) begin
          cmd.wr_shift = 1'b1;
          if (sts.at_first) begin
            state_next = S_I_LAST;
          end else begin
            cmd.idx_dec = 1'b1;
            state_next  = S_I_RD;
          end
        end else begin
          cmd.wr_new_up = 1'b1;
          cmd.cnt_inc   = 1'b1;
          cmd.res_zero  = 1'b1;
          state_next    = S_POST;
        end
      end
      S_I_LAST: begin
        cmd.wr_new_zero = 1'b1;
        cmd.cnt_inc     = 1'b1;
        cmd.res_zero    = 1'b1;
        state_next      = S_POST;
      end
      S_Q_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_Q_CHK;
      end
      S_Q_CHK: begin
        cmd.q_save = 1'b1;
        if (sts.az_gt) begin
          if (sts.at_first) begin
            cmd.idx_last = 1'b1;
            state_next   = S_Q_LRD;
          end else begin
            cmd.pair_prev = 1'b1;
            state_next    = S_SUB;
          end
        end else if (sts.at_last) begin
          cmd.pair_wrap = 1'b1;
          state_next    = S_SUB;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_Q_RD;
        end
      end
      S_Q_LRD: begin
        cmd.rd     = 1'b1;
        state_next = S_Q_LCHK;
      end
      S_Q_LCHK: begin
        cmd.pair_wrap = 1'b1;
        state_next    = S_SUB;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_POST;
      end
      S_POST: begin
        if (!sts.out_busy) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/hac_dp.sv
// hac_dp: horizon table storage, table walk registers, interpolation
// arithmetic with a bit-serial divider, and the output register.
// Depends on hac_pkg and hac_ram.
`timescale 1ns / 1ps

module hac_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  hac_pkg::cmd_t                     cmd,
  output hac_pkg::sts_t                     sts,
  input  logic [1:0]                        req_type,
  input  logic [hac_pkg::AZ_W-1:0]          azimuth,
  input  logic signed [hac_pkg::ALT_W-1:0]  altitude,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [hac_pkg::ALT_W-1:0]  horizon_alt,
  output logic                              above_horizon
);
  import hac_pkg::*;

  localparam int EXT_W = AZ_W + 2;
  localparam logic [AZ_W-1:0]         TURN_AZ = AZ_W'(FULL_TURN);
  localparam logic signed [EXT_W-1:0] TURN_S  = EXT_W'(FULL_TURN);

  // request
  req_t                    req_q;
  logic [AZ_W-1:0]         az_q;
  logic signed [ALT_W-1:0] alt_q;
  logic [AZ_W-1:0]         az_red;

  // table walk
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_m1;
  logic [ADDR_W-1:0] idx;
  logic [ENT_W-1:0]  rdata, wdata, new_ent;
  logic [ADDR_W-1:0] waddr;
  logic              we;
  logic [AZ_W-1:0]   rd_az;
  logic [ENT_W-1:0]  first_ent, prev_ent, p1_ent, p2_ent;

  // interpolation
  logic [AZ_W-1:0]            p1_az, p2_az;
  logic signed [ALT_W-1:0]    p1_alt, p2_alt;
  logic signed [EXT_W-1:0]    a1_s, den_s, t_s;
  logic [DEN_W-1:0]           den, d;
  logic                       den_zero;
  logic signed [DIFF_W-1:0]   diff, diff_next;
  logic signed [PROD_W-1:0]   prod, mag;
  logic                       neg;
  logic [DIV_W-1:0]           quo;
  logic [DEN_W-1:0]           rem;
  logic [DEN_W:0]             rsh;
  logic [DIVCNT_W-1:0]        divcnt;
  logic signed [SUM_W-1:0]    h1_x, q_x, sum;

  // result staging
  status_t                 res_status;
  logic signed [ALT_W-1:0] res_hz;

  assign az_red   = (azimuth >= TURN_AZ) ? azimuth - TURN_AZ : azimuth;
  assign count_m1 = count - 1'b1;
  assign new_ent  = {az_q, alt_q};
  assign rd_az    = rdata[ENT_W-1:ALT_W];

  assign we    = cmd.wr_shift | cmd.wr_new_up | cmd.wr_new_zero;
  assign waddr = cmd.wr_new_zero ? '0 : idx + 1'b1;
  assign wdata = cmd.wr_shift ? rdata : new_ent;

  hac_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (rdata)
  );

  assign sts.req      = req_q;
  assign sts.empty    = (count == '0);
  assign sts.full     = (count >= CNT_W'(MAX_POINTS));
  assign sts.az_gt    = (rd_az > az_q);
  assign sts.at_first = (idx == '0);
  assign sts.at_last  = ({1'b0, idx} == count_m1);
  assign sts.div_last = (divcnt == DIVCNT_W'(DIV_W - 1));
  assign sts.out_busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_t'(req_type);
      az_q  <= az_red;
      alt_q <= altitude;
    end
    if (cmd.idx_last) idx <= count_m1[ADDR_W-1:0];
    else if (cmd.idx_zero) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + 1'b1;
    else if (cmd.idx_dec) idx <= idx - 1'b1;
    if (cmd.q_save) begin
      prev_ent <= rdata;
      if (sts.at_first) first_ent <= rdata;
    end
    if (cmd.pair_prev) begin
      p1_ent <= prev_ent;
      p2_ent <= rdata;
    end else if (cmd.pair_wrap) begin
      p1_ent <= rdata;
      p2_ent <= sts.at_first ? rdata : first_ent;
    end
  end

  assign p1_az  = p1_ent[ENT_W-1:ALT_W];
  assign p2_az  = p2_ent[ENT_W-1:ALT_W];
  assign p1_alt = $signed(p1_ent[ALT_W-1:0]);
  assign p2_alt = $signed(p2_ent[ALT_W-1:0]);

  always_comb begin
    a1_s = $signed({2'b00, p1_az});
    if (p1_az > p2_az) a1_s = a1_s - TURN_S;
    den_s = $signed({2'b00, p2_az}) - a1_s;
    t_s   = $signed({2'b00, az_q}) - a1_s;
    if (t_s < 0) t_s = t_s + TURN_S;
    else if (t_s >= TURN_S) t_s = t_s - TURN_S;
    diff_next = $signed({p2_alt[ALT_W-1], p2_alt}) - $signed({p1_alt[ALT_W-1], p1_alt});
  end

  assign mag  = prod[PROD_W-1] ? -prod : prod;
  assign rsh  = {rem, quo[DIV_W-1]};
  assign h1_x = SUM_W'(p1_alt);
  assign q_x  = $signed({2'b00, quo});
  assign sum  = neg ? h1_x - q_x : h1_x + q_x;

  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      den      <= den_s[DEN_W-1:0];
      den_zero <= (den_s == '0);
      d        <= t_s[DEN_W-1:0];
      diff     <= diff_next;
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, d}) * diff;
    end
    if (cmd.prep) begin
      neg    <= prod[PROD_W-1];
      quo    <= mag[DIV_W-1:0] + DIV_W'(den >> 1);
      rem    <= '0;
      divcnt <= '0;
    end else if (cmd.div_step) begin
      divcnt <= divcnt + 1'b1;
      if (rsh >= {1'b0, den}) begin
        rem <= DEN_W'(rsh - {1'b0, den});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rsh[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_zero) begin
      res_status <= ST_OK;
      res_hz     <= '0;
    end else if (cmd.res_full) begin
      res_status <= ST_FULL;
      res_hz     <= '0;
    end else if (cmd.res_empty) begin
      res_status <= ST_EMPTY;
      res_hz     <= '0;
    end else if (cmd.fin) begin
      res_status <= ST_OK;
      res_hz     <= den_zero ? clamp_alt(h1_x) : clamp_alt(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      status        <= res_status;
      horizon_alt   <= res_hz;
      above_horizon <= (req_q == REQ_QUERY) && (alt_q > res_hz);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count above table depth");

  a_post_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> !(out_valid && out_stall))
    else $error("result posted over a stalled result");

  a_shift_in_table: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_shift || cmd.wr_new_up) |-> ({1'b0, idx} < count))
    else $error("insert write beyond table end");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count < CNT_W'(MAX_POINTS)))
    else $error("insert into full table");

  a_pair_prev: assert property (@(posedge clk) disable iff (rst)
    cmd.pair_prev |-> (idx != '0))
    else $error("bracket taken with no previous point");

endmodule

### rtl/horizon_altitude_check_unit.sv
// horizon_altitude_check_unit: top level of the horizon table and
// above-horizon test. Depends on hac_pkg, hac_ctrl, hac_dp (hac_ram).
`timescale 1ns / 1ps
//
// Requests enter on in_valid/in_stall with req_type, azimuth and altitude;
// one result per request leaves on out_valid/out_stall with status,
// horizon_alt and above_horizon. A request is taken when valid is high and
// stall is low. Clear and no-op requests, inserts into a full or empty table
// and queries on an empty table go from decode straight to posting their result.
// An insert walks the table from the top, reading and checking each entry
// and shifting it up while its azimuth is above that of the new point.
// A query walks from the bottom, reading and checking each entry in turn
// (one RAM read port, registered data), plus a read of the last entry when
// the target lies below the first point, then interpolates through the
// subtract, multiply, prepare, one-bit-per-cycle divider and finish steps.
// One request is in work at a time; the next is taken in the cycle after
// the result is posted. A finished result waits in the output register, so
// the next request is taken while out_stall holds the previous result. A
// result that finds the output register still stalled waits before posting.
// Reset (rst, synchronous) empties the table and drops any pending result.
//
module horizon_altitude_check_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [hac_pkg::AZ_W-1:0]          azimuth,
  input  logic signed [hac_pkg::ALT_W-1:0]  altitude,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [hac_pkg::ALT_W-1:0]  horizon_alt,
  output logic                              above_horizon
);
  import hac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hac_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .azimuth       (azimuth),
    .altitude      (altitude),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .horizon_alt   (horizon_alt),
    .above_horizon (above_horizon)
  );

endmodule
